// ===== rtl/core/sacrf_pkg.sv =====
// ----------------------------------------------------------------------------
// sacrf_pkg
// Shared types and constants for the set-associative cache with random fill.
// ----------------------------------------------------------------------------
`default_nettype none

package sacrf_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned WAY_OUT_W = 2;
   localparam int unsigned LFSR_W    = 16;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   // Request transaction
   typedef struct packed {
      logic                     action;      // 0 load, 1 store
      logic [ADDR_W-1:0]        address;
      logic signed [WORD_W-1:0] store_word;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic                     hit;
      logic signed [WORD_W-1:0] read_word;
      logic [WAY_OUT_W-1:0]     way_used;
   } rsp_type;

endpackage : sacrf_pkg

`default_nettype wire

// ===== rtl/core/sacrf_ram.sv =====
// ----------------------------------------------------------------------------
// sacrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacrf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : sacrf_ram

`default_nettype wire

// ===== rtl/core/set_associative_cache_random_fill_core.sv =====
// ----------------------------------------------------------------------------
// set_associative_cache_random_fill_core
// Set-associative cache with lowest-invalid or LFSR-random way choice.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                      Handshake
//   -------   ------------------------   ----------------------------------
//   request   start, busy, req_data      taken on start && !busy
//   response  rsp_strobe, rsp_data       one cycle per strobe, no back-pressure
//
// Steps (start to strobe), with power-of-two SETS and WAYS:
//   load hit            one line RAM read per way, then decide
//   load miss / store   the scan and decide steps, then the line write
// A non power-of-two SETS adds the index/tag split (reciprocal
// multiply for the quotient, multiply back for the remainder), and a random
// fill with non power-of-two WAYS adds a like split of the LFSR value by
// WAYS; both use the one shared multiplier.
// After reset the line RAM is swept clear, one line per cycle over every
// address, while busy stays high.
// Responses cannot be stalled; the response register lets the next request in
// during the strobe cycle.
//
`default_nettype none

module set_associative_cache_random_fill_core #(
   parameter int unsigned WAYS        = 4,
   parameter int unsigned SETS        = 64,
   parameter int unsigned OFFSET_BITS = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire sacrf_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output sacrf_pkg::rsp_type     rsp_data
);

   import sacrf_pkg::*;

   // Address split widths
   localparam int unsigned BW  = ADDR_W - OFFSET_BITS;              // block number
   localparam int unsigned SW  = $clog2(SETS);                      // set index
   localparam int unsigned TW  = BW - ($clog2(SETS + 1) - 1);       // tag
   localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;     // way index
   localparam int unsigned CW  = $clog2(WAYS + 1);                  // scan counter
   localparam int unsigned AW  = WW + SW;                           // RAM address
   localparam int unsigned DEPTH = 1 << AW;

   localparam bit SETS_POW2 = (SETS & (SETS - 1)) == 0;
   localparam bit WAYS_POW2 = (WAYS & (WAYS - 1)) == 0;

   // Reciprocal split: q = (x * M) >> S is exact for every x below 2**N
   // when S = N + ceil(log2 d) and M = ceil(2**S / d).
   localparam int unsigned SET_SH = BW + $clog2(SETS);
   localparam int unsigned WAY_SH = LFSR_W + $clog2(WAYS);
   localparam longint unsigned SET_RECIP =
      ((64'd1 << SET_SH) + 64'(SETS) - 64'd1) / 64'(SETS);
   localparam longint unsigned WAY_RECIP =
      ((64'd1 << WAY_SH) + 64'(WAYS) - 64'd1) / 64'(WAYS);
   localparam int unsigned MW = BW + 1;                             // multiplier b
   localparam int unsigned PW = BW + MW;                            // product

   typedef struct packed {
      logic          valid;
      logic [TW-1:0] tag;
      logic [31:0]   word;
   } line_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIVSET,
      S_SCAN,
      S_DECIDE,
      S_DIVWAY,
      S_WRITE
   } state_type;

   // Registers
   state_type           state_ff, state_in;
   logic                action_ff, action_in;
   logic [WORD_W-1:0]   sword_ff, sword_in;
   logic [SW-1:0]       set_ff, set_in;
   logic [TW-1:0]       tag_ff, tag_in;
   logic [BW-1:0]       dvd_ff, dvd_in;
   logic [BW-1:0]       quo_ff, quo_in;
   logic                phase_ff, phase_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                hit_found_ff, hit_found_in;
   logic [WW-1:0]       hit_way_ff, hit_way_in;
   logic [WORD_W-1:0]   hit_word_ff, hit_word_in;
   logic                inv_found_ff, inv_found_in;
   logic [WW-1:0]       inv_way_ff, inv_way_in;
   logic [WW-1:0]       way_ff, way_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // Shared multiplier
   logic [BW-1:0]       mul_a;
   logic [MW-1:0]       mul_b;
   logic [PW-1:0]       mul_p;
   logic [BW-1:0]       mod_rem;

   // LFSR step
   logic [LFSR_W-1:0]   lfsr_next;

   // Line RAM
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   line_type            ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   line_type            ram_rd_data;

   logic [BW-1:0]       req_block;
   logic [WW-1:0]       chk_way;

   sacrf_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_block = BW'(req_data.address >> OFFSET_BITS);
   assign chk_way   = WW'(idx_ff - CW'(1));

   // First phase multiplies by the reciprocal, second by the divisor
   always_comb begin
      mul_a = phase_ff ? quo_ff : dvd_ff;
      if (state_ff == S_DIVWAY) begin
         mul_b = phase_ff ? MW'(WAYS) : MW'(WAY_RECIP);
      end else begin
         mul_b = phase_ff ? MW'(SETS) : MW'(SET_RECIP);
      end
   end

   assign mul_p   = PW'(mul_a) * PW'(mul_b);
   assign mod_rem = dvd_ff - BW'(mul_p);

   // Taps 16,14,13,11, shifted in at the top
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                       lfsr_ff[LFSR_W-1:1]};

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      sword_in      = sword_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      hit_found_in  = hit_found_ff;
      hit_way_in    = hit_way_ff;
      hit_word_in   = hit_word_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      way_in        = way_ff;
      lfsr_in       = lfsr_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = {WW'(idx_ff), set_ff};

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               action_in    = req_data.action;
               sword_in     = req_data.store_word;
               dvd_in       = req_block;
               phase_in     = 1'b0;
               idx_in       = '0;
               hit_found_in = 1'b0;
               inv_found_in = 1'b0;
               if (SETS_POW2) begin
                  set_in   = SW'(req_block);
                  tag_in   = TW'(req_block >> SW);
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DIVSET;
               end
            end
         end

         S_DIVSET: begin
            if (!phase_ff) begin
               quo_in   = BW'(mul_p >> SET_SH);
               phase_in = 1'b1;
            end else begin
               set_in   = SW'(mod_rem);
               tag_in   = TW'(quo_ff);
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // read way idx, check the way read last cycle
            if (idx_ff != '0) begin
               if (ram_rd_data.valid && (ram_rd_data.tag == tag_ff) && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_way_in   = chk_way;
                  hit_word_in  = ram_rd_data.word;
               end
               if (!ram_rd_data.valid && !inv_found_ff) begin
                  inv_found_in = 1'b1;
                  inv_way_in   = chk_way;
               end
            end
            if (idx_ff == CW'(WAYS)) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         S_DECIDE: begin
            if (!action_ff && hit_found_ff) begin
               rsp_strobe_in         = 1'b1;
               rsp_data_in.hit       = 1'b1;
               rsp_data_in.read_word = hit_word_ff;
               rsp_data_in.way_used  = WAY_OUT_W'(hit_way_ff);
               state_in              = S_IDLE;
            end else if (inv_found_ff) begin
               way_in   = inv_way_ff;
               state_in = S_WRITE;
            end else begin
               lfsr_in = lfsr_next;
               if (WAYS_POW2) begin
                  way_in   = WW'(lfsr_next) & WW'(WAYS - 1);
                  state_in = S_WRITE;
               end else begin
                  dvd_in   = BW'(lfsr_next);
                  phase_in = 1'b0;
                  state_in = S_DIVWAY;
               end
            end
         end

         S_DIVWAY: begin
            if (!phase_ff) begin
               quo_in   = BW'(mul_p >> WAY_SH);
               phase_in = 1'b1;
            end else begin
               way_in   = WW'(mod_rem);
               state_in = S_WRITE;
            end
         end

         S_WRITE: begin
            ram_wr_en             = 1'b1;
            ram_wr_addr           = {way_ff, set_ff};
            ram_wr_data.valid     = 1'b1;
            ram_wr_data.tag       = tag_ff;
            ram_wr_data.word      = action_ff ? sword_ff : '0;
            rsp_strobe_in         = 1'b1;
            rsp_data_in.hit       = 1'b0;
            rsp_data_in.read_word = '0;
            rsp_data_in.way_used  = WAY_OUT_W'(way_ff);
            state_in              = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         lfsr_ff       <= LFSR_SEED;
         rsp_strobe_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
         inv_found_ff  <= 1'b0;
         idx_ff        <= '0;
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         lfsr_ff       <= lfsr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         hit_found_ff  <= hit_found_in;
         inv_found_ff  <= inv_found_in;
         idx_ff        <= idx_in;
         phase_ff      <= phase_in;
      end
      // transaction payload
      action_ff   <= action_in;
      sword_ff    <= sword_in;
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      hit_way_ff  <= hit_way_in;
      hit_word_ff <= hit_word_in;
      inv_way_ff  <= inv_way_in;
      way_ff      <= way_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule : set_associative_cache_random_fill_core

`default_nettype wire

// ===== rtl/core/sacrf_checker.sv =====
// ----------------------------------------------------------------------------
// sacrf_checker
// Port-level checks on the cache core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module sacrf_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_strobe,
   input wire sacrf_pkg::rsp_type rsp_data
);

   // an accepted transaction holds the core busy, with no response yet
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("core not busy after accepting a transaction");

   // response is shown once the core is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while core busy");

   // the response strobe is never high on consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe on consecutive cycles");

   // misses and stores return a zero word
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |-> (rsp_data.read_word == '0))
      else $error("non-zero word without a hit");

endmodule : sacrf_checker

bind set_associative_cache_random_fill_core sacrf_checker u_sacrf_checker (.*);

`default_nettype wire

// ===== verif/set_associative_cache_random_fill_core_test.sv =====
// ----------------------------------------------------------------------------
// set_associative_cache_random_fill_core_test
// Self-checking bench for the random-fill set-associative cache. Each request
// transaction is pushed through a behavioural copy of the cache state. The
// expected response is queued and compared, field by field, with every strobed
// response. Directed tasks cover the corner cases, then random traffic runs.
// ----------------------------------------------------------------------------
`default_nettype none

module set_associative_cache_random_fill_core_test;

   import sacrf_pkg::*;

   localparam int unsigned WAYS        = 4;
   localparam int unsigned SETS        = 64;
   localparam int unsigned OFFSET_BITS = 2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_STORE = 1'b1;

   // generous: reset sweep plus ~700 transactions at worst gap and latency
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_GAP      = 12;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   set_associative_cache_random_fill_core #(
      .WAYS        (WAYS),
      .SETS        (SETS),
      .OFFSET_BITS (OFFSET_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Behavioural cache state, mirrors the line RAM and the replacement LFSR
   // ------------------------------------------------------------------------
   logic        line_valid [WAYS][SETS];
   logic [31:0] line_tag   [WAYS][SETS];
   logic [31:0] line_word  [WAYS][SETS];
   logic [15:0] victim_lfsr;

   rsp_type due_responses[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   int      burst_left = 0;

   initial begin
      for (int w = 0; w < WAYS; w++) begin
         for (int s = 0; s < SETS; s++) begin
            line_valid[w][s] = 1'b0;
            line_tag[w][s]   = '0;
            line_word[w][s]  = '0;
         end
      end
      victim_lfsr = LFSR_SEED;
   end

   // Lowest invalid way; only a full set steps the LFSR and takes it mod WAYS.
   function automatic int unsigned pick_way(input int unsigned set);
      logic        fb;
      int unsigned w;
      for (w = 0; w < WAYS; w++) begin
         if (!line_valid[w][set]) begin
            return w;
         end
      end
      fb          = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
      victim_lfsr = {fb, victim_lfsr[15:1]};
      return victim_lfsr % WAYS;
   endfunction

   // Applies one request transaction to the state, returns the response due.
   function automatic rsp_type cache_access(input req_type r);
      logic [31:0] blk;
      logic [31:0] tag;
      int unsigned set;
      int unsigned w;
      logic        found;
      rsp_type     rsp;
      blk   = r.address >> OFFSET_BITS;
      set   = blk % SETS;
      tag   = blk / SETS;
      found = 1'b0;
      rsp   = '0;
      if (r.action == ACT_LOAD) begin
         // duplicate tags are possible after stores: lowest matching way wins
         for (w = 0; w < WAYS; w++) begin
            if (!found && line_valid[w][set] && line_tag[w][set] == tag) begin
               found         = 1'b1;
               rsp.hit       = 1'b1;
               rsp.read_word = line_word[w][set];
               rsp.way_used  = w[WAY_OUT_W-1:0];
            end
         end
      end
      if (!found) begin
         // store placement, or fill of a load miss with word 0
         w                   = pick_way(set);
         line_valid[w][set]  = 1'b1;
         line_tag[w][set]    = tag;
         line_word[w][set]   = (r.action == ACT_STORE) ? r.store_word : '0;
         rsp.way_used        = w[WAY_OUT_W-1:0];
      end
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Request side: bursts of back-to-back transactions, most separated by gaps
   // ------------------------------------------------------------------------
   task automatic send_request(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, MAX_GAP);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= item;
      // taken at the first edge that sees busy low
      do @(posedge clock); while (busy);
      due_responses.push_back(cache_access(item));
   endtask

   function automatic req_type make_request(input logic act, input logic [31:0] addr,
                                            input logic [31:0] word);
      req_type r;
      r.action     = act;
      r.address    = addr;
      r.store_word = word;
      return r;
   endfunction

   function automatic logic [31:0] line_address(input logic [23:0] tag,
                                                input logic [5:0] set,
                                                input logic [1:0] offset);
      return {tag, set, offset};
   endfunction

   // ------------------------------------------------------------------------
   // Response side: responses cannot be held off, check every strobe
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("cycle %0d: %s mismatch, expected %h, got %h",
               cycle_count, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_responses.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_data.read_word);
         end else begin
            want = due_responses.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 32'(want.hit), 32'(rsp_data.hit));
            if (rsp_data.read_word !== want.read_word)
               report_mismatch("read_word", want.read_word, rsp_data.read_word);
            if (rsp_data.way_used !== want.way_used)
               report_mismatch("way_used", 32'(want.way_used), 32'(rsp_data.way_used));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------------

   // Empty cache: misses fill way 0 with word 0, extreme addresses, then a hit.
   task automatic test_cold_misses;
      send_request(make_request(ACT_LOAD, 32'h0000_0000, 32'h1234_5678));
      send_request(make_request(ACT_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_request(ACT_LOAD, 32'h0000_0003, 32'h0));
   endtask

   // Stores then loads of extreme words; offset bits alias the same line.
   task automatic test_store_then_load;
      send_request(make_request(ACT_STORE, line_address(24'h000001, 6'd1, 2'd0),
                                32'h7FFF_FFFF));
      send_request(make_request(ACT_LOAD, line_address(24'h000001, 6'd1, 2'd3), 32'h0));
      send_request(make_request(ACT_STORE, line_address(24'h5A5A5A, 6'd2, 2'd1),
                                32'h8000_0000));
      send_request(make_request(ACT_LOAD, line_address(24'h5A5A5A, 6'd2, 2'd2), 32'h0));
      send_request(make_request(ACT_STORE, line_address(24'hA5A5A5, 6'd3, 2'd0),
                                32'hFFFF_FFFF));
      send_request(make_request(ACT_LOAD, line_address(24'hA5A5A5, 6'd3, 2'd0), 32'h0));
   endtask

   // A store to an address already held lands in a new way: the load then
   // takes the lowest matching way (set 63 already holds the all-ones tag).
   task automatic test_duplicate_tags;
      send_request(make_request(ACT_STORE, 32'hFFFF_FFFC, 32'h0BAD_F00D));
      send_request(make_request(ACT_LOAD, 32'hFFFF_FFFE, 32'h0));
   endtask

   // Fill every way of one set, then force random replacement by store and
   // by load miss, and probe the survivors.
   task automatic test_full_set_replacement;
      for (int t = 1; t <= WAYS; t++) begin
         send_request(make_request(ACT_STORE, line_address(24'(t), 6'd5, 2'd0),
                                   32'(t * 32'h1111_1111)));
      end
      send_request(make_request(ACT_STORE, line_address(24'h000010, 6'd5, 2'd0),
                                32'hCAFE_0001));
      send_request(make_request(ACT_LOAD, line_address(24'h000020, 6'd5, 2'd0), 32'h0));
      send_request(make_request(ACT_LOAD, line_address(24'h000001, 6'd5, 2'd0), 32'h0));
      send_request(make_request(ACT_LOAD, line_address(24'h000010, 6'd5, 2'd0), 32'h0));
   endtask

   // ------------------------------------------------------------------------
   // Random traffic: mostly a few hot sets and tags so that hits, refills and
   // random replacement all happen often; the rest uses any address.
   // ------------------------------------------------------------------------
   task automatic test_random_traffic(input int count);
      logic [5:0]  hot_set [4];
      logic [23:0] hot_tag [6];
      logic [1:0]  offset;
      logic [31:0] addr;
      logic [31:0] word;
      logic        act;
      for (int k = 0; k < 4; k++) hot_set[k] = 6'($urandom);
      for (int k = 0; k < 6; k++) hot_tag[k] = 24'($urandom);
      for (int i = 0; i < count; i++) begin
         act    = ($urandom_range(0, 9) < 4) ? ACT_STORE : ACT_LOAD;
         offset = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 7) begin
            addr = line_address(hot_tag[$urandom_range(0, 5)],
                                hot_set[$urandom_range(0, 3)], offset);
         end else begin
            addr = $urandom;
         end
         case ($urandom_range(0, 7))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'hFFFF_FFFF;
            3:       word = 32'h0000_0000;
            default: word = $urandom;
         endcase
         send_request(make_request(act, addr, word));
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_cold_misses();
      test_store_then_load();
      test_duplicate_tags();
      test_full_set_replacement();
      test_random_traffic(700);

      start <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (WAYS + 10) @(posedge clock);

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule : set_associative_cache_random_fill_core_test

`default_nettype wire

// ===== filelist.f =====
rtl/core/sacrf_pkg.sv
rtl/core/sacrf_ram.sv
rtl/core/set_associative_cache_random_fill_core.sv
rtl/core/sacrf_checker.sv
verif/set_associative_cache_random_fill_core_test.sv
